// File: hdl/brot90_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brot90_pkg
// Shared types and constants for the rotated 1bpp frame store.
// ----------------------------------------------------------------------------
package brot90_pkg;

    // Fixed field widths of the transaction ports
    localparam int INDEX_W = 13;
    localparam int PIXEL_W = 8;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REMAINDER,
        ST_SETUP,
        ST_GATHER,
        ST_RESPOND
    } brot90_state_t;

endpackage

// File: hdl/bitmap_rotate_90_1bpp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rotate_90_1bpp
// One-bit-per-pixel frame store with 90-degree clockwise rotated readout.
// ----------------------------------------------------------------------------
// A write transaction stores one packed source byte; it gives no response
// unless its index lies outside the frame. A read transaction returns one
// byte of the rotated image. A read passes through a divide state, whose
// reciprocal multiplication gives the destination row, a remainder state
// that forms the column byte from it, a setup state that forms the first
// source address, then a gather state in which the single memory port
// fetches one source byte per destination bit and collects it in the next
// cycle, and a response state. An out-of-range index gives a response with
// bad_index set through the response state. The response state waits while
// the output register still holds an untaken response. The block is not
// ready while a transaction is in progress. Stored bytes are undefined
// until written; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module bitmap_rotate_90_1bpp #(
    parameter int SOURCE_WIDTH  = 264,
    parameter int SOURCE_HEIGHT = 176
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [brot90_pkg::INDEX_W-1:0]     byte_index,
    input  logic [brot90_pkg::PIXEL_W-1:0]     pixel_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [brot90_pkg::PIXEL_W-1:0]     rotated_byte,
    output logic                               bad_index
);
    import brot90_pkg::*;

    // Frame geometry
    localparam int SRC_ROW_BYTES   = (SOURCE_WIDTH + 7) / 8;
    localparam int DST_ROW_BYTES   = (SOURCE_HEIGHT + 7) / 8;
    localparam int SRC_FRAME_BYTES = SRC_ROW_BYTES * SOURCE_HEIGHT;
    localparam int DST_FRAME_BYTES = DST_ROW_BYTES * SOURCE_WIDTH;
    localparam int AW  = $clog2(SRC_FRAME_BYTES);
    localparam int RW  = $clog2(DST_ROW_BYTES) + 1;
    localparam int YW  = $clog2(SOURCE_HEIGHT);
    localparam int DXW = $clog2(DST_ROW_BYTES * 8);

    // Reciprocal of the destination row length, exact for any 13-bit index
    localparam int DIV_SHIFT = INDEX_W + $clog2(DST_ROW_BYTES);
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + DST_ROW_BYTES - 1) / DST_ROW_BYTES;
    localparam int PW        = 2 * INDEX_W + 1;

    brot90_state_t state_reg, state_next;

    logic [3:0]          cnt_reg, cnt_next;
    logic [INDEX_W-1:0]  num_reg, num_next;
    logic [INDEX_W-1:0]  quo_reg, quo_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [DXW-1:0]      dx_reg, dx_next;
    logic                pend_reg, pend_next;
    logic [PIXEL_W-1:0]  res_byte_reg, res_byte_next;
    logic                res_bad_reg, res_bad_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]  out_byte_reg, out_byte_next;
    logic                out_bad_reg, out_bad_next;

    // Frame memory, single port
    logic [PIXEL_W-1:0]  frame_mem [SRC_FRAME_BYTES];
    logic [PIXEL_W-1:0]  rdata_reg;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic                mem_re;

    // Divider datapath
    logic [PW-1:0]       recip_prod;
    logic [INDEX_W-1:0]  rem_full;

    // Address setup datapath
    logic [YW-1:0]       src_y0;
    logic [AW-1:0]       addr_base;
    logic                dx_ok;
    logic                gathered_bit;

    logic                in_fire;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign rotated_byte = out_byte_reg;
    assign bad_index    = out_bad_reg;

    // Row by reciprocal multiplication, column byte from the row
    assign recip_prod = PW'(num_reg) * PW'(DIV_RECIP);
    assign rem_full   = num_reg - quo_reg * INDEX_W'(DST_ROW_BYTES);

    // First source address: bottom row of the column band, byte of src_x
    assign src_y0    = YW'(SOURCE_HEIGHT - 1) - YW'({rem_reg, 3'b000});
    assign addr_base = AW'(AW'(src_y0) * AW'(SRC_ROW_BYTES))
                     + AW'(num_reg[INDEX_W-1:3]);

    // Destination column still inside the frame
    assign dx_ok = (32'(dx_reg) < 32'(SOURCE_HEIGHT));

    // Pixel of src_x within the fetched byte, leftmost in bit 7
    assign gathered_bit = pend_reg & rdata_reg[~num_reg[2:0]];

    // Memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= pixel_byte;
        end
        if (mem_re)
        begin
            rdata_reg <= frame_mem[mem_addr];
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        addr_reg     <= addr_next;
        dx_reg       <= dx_next;
        res_byte_reg <= res_byte_next;
        res_bad_reg  <= res_bad_next;
        out_byte_reg <= out_byte_next;
        out_bad_reg  <= out_bad_next;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        addr_next      = addr_reg;
        dx_next        = dx_reg;
        pend_next      = 1'b0;
        res_byte_next  = res_byte_reg;
        res_bad_next   = res_bad_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_bad_next   = out_bad_reg;
        mem_addr       = addr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        // Response leaves the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_addr = AW'(byte_index);
                if (in_fire)
                begin
                    res_byte_next = '0;
                    res_bad_next  = 1'b1;
                    if (opcode == OP_WRITE)
                    begin
                        if (32'(byte_index) < 32'(SRC_FRAME_BYTES))
                        begin
                            mem_we = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_RESPOND;
                        end
                    end
                    else if (32'(byte_index) < 32'(DST_FRAME_BYTES))
                    begin
                        res_bad_next = 1'b0;
                        num_next     = byte_index;
                        rem_next     = '0;
                        cnt_next     = '0;
                        state_next   = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_RESPOND;
                    end
                end
            end

            // Destination row (source column)
            ST_DIVIDE:
            begin
                quo_next   = INDEX_W'(recip_prod >> DIV_SHIFT);
                state_next = ST_REMAINDER;
            end

            // Destination column byte; num now holds the row
            ST_REMAINDER:
            begin
                rem_next   = RW'(rem_full);
                num_next   = quo_reg;
                state_next = ST_SETUP;
            end

            ST_SETUP:
            begin
                addr_next = addr_base;
                dx_next   = DXW'({rem_reg, 3'b000});
                cnt_next  = '0;
                state_next = ST_GATHER;
            end

            // Issue one fetch per bit, collect it in the next cycle
            ST_GATHER:
            begin
                if (!cnt_reg[3])
                begin
                    mem_re    = dx_ok;
                    pend_next = dx_ok;
                    addr_next = addr_reg - AW'(SRC_ROW_BYTES);
                    dx_next   = dx_reg + DXW'(1);
                end
                if (cnt_reg != 4'd0)
                begin
                    res_byte_next = {res_byte_reg[PIXEL_W-2:0], gathered_bit};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg[3])
                begin
                    state_next = ST_RESPOND;
                end
            end

            ST_RESPOND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_bad_next   = res_bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
